/* sv/tccw_pkg.sv */
// ---------------------------------------------------------------------------
// tccw_pkg
// Shared types, codes and the digit to character map for the text console
// cell writer.
// ---------------------------------------------------------------------------
package tccw_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_PUT_CHAR = 2'd0;
   localparam logic [1:0] CMD_HEX      = 2'd1;
   localparam logic [1:0] CMD_DEC      = 2'd2;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] MINUS_CODE   = 8'h2D;
   localparam logic [7:0] COLOR_RESET  = 8'd23;

   localparam int ADDR_W   = 11;
   localparam int SUM_W    = 12;  // holds any row base plus column up to 32 x 128
   localparam int NUM_W    = 32;
   localparam int DIGITS   = 10;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int STEP_W   = 6;
   localparam int CNT_W    = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // ascii for one hex digit, upper case
   function automatic logic [7:0] digit_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

/* sv/tccw_bcd_unit.sv */
// ---------------------------------------------------------------------------
// tccw_bcd_unit
// Binary to packed BCD conversion, one input bit per cycle (shift and add 3).
// ---------------------------------------------------------------------------
module tccw_bcd_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tccw_pkg::NUM_W-1:0] value,
   output logic                       done,
   output logic [tccw_pkg::BCD_W-1:0] bcd
);

   logic [tccw_pkg::NUM_W-1:0]  bin_ff, bin_in;
   logic [tccw_pkg::BCD_W-1:0]  bcd_ff, bcd_in;
   logic [tccw_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [tccw_pkg::BCD_W-1:0]  adj;

   // every digit of five or more gets three added before the shift
   always_comb begin
      for (int i = 0; i < tccw_pkg::DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         step_in = tccw_pkg::STEP_W'(tccw_pkg::NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {adj[tccw_pkg::BCD_W-2:0], bin_ff[tccw_pkg::NUM_W-1]};
         bin_in  = {bin_ff[tccw_pkg::NUM_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == tccw_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

/* sv/text_console_cell_writer.sv */
// ---------------------------------------------------------------------------
// text_console_cell_writer
// Prints characters, hex and signed decimal numbers as 16-bit screen cell
// writes at a wrapping cursor.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_cmd, req_char_code, req_number
//  rsp      out        rsp_valid/rsp_stall  rsp_cell_address, rsp_cell_value, rsp_last
//  csr      in         csr_valid/csr_ready  csr_text_color
//
//  One item at a time; req_stall is high until the last cell is in the output register.
//  Character: one cell. Hex: eight cells, one per digit. Decimal: the shift-and-add-3
//  converter, then the leading zero stage, which drops one zero at a time, then one
//  cell a cycle while rsp_stall is low. Newline and unused commands write no cell.
//  rsp_stall holds the output register and pauses emission.
//  Synchronous reset clears the cursor and sets the attribute to 23.
// ---------------------------------------------------------------------------
module text_console_cell_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [7:0]                  req_char_code,
   input  logic [tccw_pkg::NUM_W-1:0]  req_number,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tccw_pkg::ADDR_W-1:0] rsp_cell_address,
   output logic [15:0]                 rsp_cell_value,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [7:0]                  csr_text_color
);

   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   tccw_pkg::state_type state_ff, state_in;

   logic [7:0]                  color_ff;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [tccw_pkg::SUM_W-1:0]  base_ff, base_in;

   logic [tccw_pkg::BCD_W-1:0]  sh_ff;
   logic [tccw_pkg::CNT_W-1:0]  cnt_ff;
   logic                        neg_ff;
   logic                        char_mode_ff;
   logic [7:0]                  char_ff;

   logic                        rsp_valid_ff;
   logic [tccw_pkg::ADDR_W-1:0] addr_ff;
   logic [15:0]                 value_ff;
   logic                        last_ff;

   logic                        req_take;
   logic                        out_free;
   logic                        emit_go;
   logic                        emit_last;
   logic                        skip_shift;
   logic                        bcd_start;
   logic                        bcd_done;
   logic [tccw_pkg::BCD_W-1:0]  bcd_value;
   logic [tccw_pkg::NUM_W-1:0]  magnitude;
   logic                        is_newline;
   logic [7:0]                  emit_char;
   logic [tccw_pkg::SUM_W-1:0]  cell_sum;

   tccw_bcd_unit u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .value (magnitude),
      .done  (bcd_done),
      .bcd   (bcd_value)
   );

   assign is_newline = (req_char_code == tccw_pkg::NEWLINE_CODE);
   assign magnitude  = req_number[tccw_pkg::NUM_W-1] ? (~req_number + 1'b1) : req_number;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_last  = !neg_ff && (cnt_ff == tccw_pkg::CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tccw_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  tccw_pkg::CMD_PUT_CHAR: if (!is_newline) state_in = tccw_pkg::ST_EMIT;
                  tccw_pkg::CMD_HEX:      state_in = tccw_pkg::ST_EMIT;
                  tccw_pkg::CMD_DEC:      state_in = tccw_pkg::ST_CONV;
                  default:                state_in = tccw_pkg::ST_IDLE;
               endcase
            end
         end
         tccw_pkg::ST_CONV: begin
            if (bcd_done) state_in = tccw_pkg::ST_SKIP;
         end
         tccw_pkg::ST_SKIP: begin
            if (!(sh_ff[tccw_pkg::BCD_W-1 -: 4] == 4'd0 && cnt_ff > tccw_pkg::CNT_W'(1))) begin
               state_in = tccw_pkg::ST_EMIT;
            end
         end
         tccw_pkg::ST_EMIT: begin
            if (out_free && emit_last) state_in = tccw_pkg::ST_IDLE;
         end
         default: state_in = tccw_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall  = 1'b1;
      req_take   = 1'b0;
      bcd_start  = 1'b0;
      skip_shift = 1'b0;
      emit_go    = 1'b0;
      unique case (state_ff)
         tccw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            req_take  = req_valid;
            bcd_start = req_valid && (req_cmd == tccw_pkg::CMD_DEC);
         end
         tccw_pkg::ST_CONV: begin
         end
         tccw_pkg::ST_SKIP: begin
            skip_shift = (sh_ff[tccw_pkg::BCD_W-1 -: 4] == 4'd0) && (cnt_ff > tccw_pkg::CNT_W'(1));
         end
         tccw_pkg::ST_EMIT: begin
            emit_go = out_free;
         end
         default: begin
         end
      endcase
   end

   // character for the cell about to be written
   always_comb begin
      if (neg_ff) begin
         emit_char = tccw_pkg::MINUS_CODE;
      end else if (char_mode_ff) begin
         emit_char = char_ff;
      end else begin
         emit_char = tccw_pkg::digit_char(sh_ff[tccw_pkg::BCD_W-1 -: 4]);
      end
   end

   assign cell_sum = base_ff + {{(tccw_pkg::SUM_W-COL_W){1'b0}}, col_ff};

   // cursor: advance after each cell, newline clears the column and moves down
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if ((emit_go && col_ff == COL_W'(COLUMNS - 1)) ||
          (req_take && req_cmd == tccw_pkg::CMD_PUT_CHAR && is_newline)) begin
         col_in = '0;
         if (row_ff == ROW_W'(ROWS - 1)) begin
            row_in  = '0;
            base_in = '0;
         end else begin
            row_in  = row_ff + 1'b1;
            base_in = base_ff + tccw_pkg::SUM_W'(COLUMNS);
         end
      end else if (emit_go) begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tccw_pkg::ST_IDLE;
         color_ff     <= tccw_pkg::COLOR_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         base_ff  <= base_in;
         if (csr_valid) begin
            color_ff <= csr_text_color;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // work registers for the item in progress
   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff      <= req_char_code;
         char_mode_ff <= (req_cmd == tccw_pkg::CMD_PUT_CHAR);
         if (req_cmd == tccw_pkg::CMD_HEX) begin
            sh_ff  <= {req_number, 8'd0};
            cnt_ff <= tccw_pkg::CNT_W'(8);
            neg_ff <= 1'b0;
         end else if (req_cmd == tccw_pkg::CMD_DEC) begin
            cnt_ff <= tccw_pkg::CNT_W'(tccw_pkg::DIGITS);
            neg_ff <= req_number[tccw_pkg::NUM_W-1];
         end else begin
            cnt_ff <= tccw_pkg::CNT_W'(1);
            neg_ff <= 1'b0;
         end
      end else if (state_ff == tccw_pkg::ST_CONV && bcd_done) begin
         sh_ff <= bcd_value;
      end else if (skip_shift) begin
         sh_ff  <= {sh_ff[tccw_pkg::BCD_W-5:0], 4'd0};
         cnt_ff <= cnt_ff - 1'b1;
      end else if (emit_go) begin
         if (neg_ff) begin
            neg_ff <= 1'b0;
         end else begin
            sh_ff  <= {sh_ff[tccw_pkg::BCD_W-5:0], 4'd0};
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (emit_go) begin
         addr_ff  <= cell_sum[tccw_pkg::ADDR_W-1:0];
         value_ff <= {color_ff, emit_char};
         last_ff  <= emit_last;
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_address = addr_ff;
   assign rsp_cell_value   = value_ff;
   assign rsp_last         = last_ff;

endmodule
